FILE: hdl/igfcs_pkg.sv
// Package: shared types, constants and helpers of the igniter fire and continuity sequencer.
package igfcs_pkg;

  localparam int ADC_BITS  = 12;
  localparam int TIME_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int TH_BITS = 12;
  localparam int DUR_BITS = 16;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_FIRE  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_ONE  = 2'd1;
  localparam logic [1:0] CH_TWO  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PATH_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_TIME    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_TIME      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_TIME     = 3'd4;

  localparam logic [TH_BITS-1:0]  PATH_THRESHOLD_RST = 12'd500;
  localparam logic [TH_BITS-1:0]  OPEN_THRESHOLD_RST = 12'd3000;
  localparam logic [DUR_BITS-1:0] SETTLE_TIME_RST    = 16'd50;
  localparam logic [DUR_BITS-1:0] IDLE_TIME_RST      = 16'd400;
  localparam logic [DUR_BITS-1:0] PULSE_TIME_RST     = 16'd500;

  typedef enum logic [2:0] {
    PH_LOW_ON  = 3'b001,
    PH_LOW_OFF = 3'b010,
    PH_IDLE    = 3'b100
  } igfcs_phase_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [TIME_BITS-1:0] now_time;
    logic [1:0]          channel;
    logic [ADC_BITS-1:0] sense_one_a;
    logic [ADC_BITS-1:0] sense_one_b;
    logic [ADC_BITS-1:0] sense_one_c;
    logic [ADC_BITS-1:0] sense_two_a;
    logic [ADC_BITS-1:0] sense_two_b;
    logic [ADC_BITS-1:0] sense_two_c;
  } igfcs_in_t;

  typedef struct packed {
    logic                high_one_drive;
    logic                high_two_drive;
    logic                low_drive;
    logic                firing;
    logic [ADC_BITS-1:0] one_count;
    logic                one_good;
    logic                one_open;
    logic                one_shorted;
    logic [ADC_BITS-1:0] two_count;
    logic                two_good;
    logic                two_open;
    logic                two_shorted;
  } igfcs_out_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] count;
    logic                good;
    logic                open;
    logic                shorted;
  } igfcs_verdict_t;

  function automatic logic [ADC_BITS-1:0] median3(input logic [ADC_BITS-1:0] a,
                                                  input logic [ADC_BITS-1:0] b,
                                                  input logic [ADC_BITS-1:0] c);
    logic [ADC_BITS-1:0] lo;
    logic [ADC_BITS-1:0] hi;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    if (hi > c) begin
      median3 = (lo > c) ? lo : c;
    end else begin
      median3 = hi;
    end
  endfunction

  function automatic logic time_reached(input logic [TIME_BITS-1:0] now,
                                        input logic [TIME_BITS-1:0] due);
    logic [TIME_BITS-1:0] diff;
    diff = now - due;
    time_reached = ~diff[TIME_BITS-1];
  endfunction

endpackage

FILE: hdl/igniter_fire_and_continuity_sequencer_unit.sv
// Top level: igniter fire and continuity sequencer with registered result stage.
// The block takes one item per unstalled clock and returns one result item for each, in the
// next cycle, from a single output register; in_stall rises only while that register holds
// a result that the far side stalls. Sensing phases, fire pulses and deadlines run on the
// millisecond timestamps carried by the items, not on the clock. Configuration writes are
// taken in every cycle (cfg_ready stays high); indexes past the register list are dropped.
module igniter_fire_and_continuity_sequencer_unit
  import igfcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  igfcs_in_t                in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output igfcs_out_t               out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [TH_BITS-1:0]   path_threshold_r;
  logic [TH_BITS-1:0]   open_threshold_r;
  logic [DUR_BITS-1:0]  settle_time_r;
  logic [DUR_BITS-1:0]  idle_time_r;
  logic [DUR_BITS-1:0]  pulse_time_r;

  logic                 started_r, started_nxt;
  igfcs_phase_t         phase_r, phase_nxt;
  logic [TIME_BITS-1:0] deadline_r, deadline_nxt;
  logic [1:0]           active_r, active_nxt;
  logic [TIME_BITS-1:0] pulse_start_r, pulse_start_nxt;
  logic [ADC_BITS-1:0]  present_one_r, present_one_nxt;
  logic [ADC_BITS-1:0]  present_two_r, present_two_nxt;
  logic                 cycle_valid_r, cycle_valid_nxt;
  igfcs_verdict_t       verdict_one_r, verdict_one_nxt;
  igfcs_verdict_t       verdict_two_r, verdict_two_nxt;
  logic [2:0]           pins_r, pins_nxt;

  logic                 out_valid_r;
  igfcs_out_t           out_data_r, out_data_nxt;

  logic                 accept;
  logic [ADC_BITS-1:0]  med_one;
  logic [ADC_BITS-1:0]  med_two;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] settle_due;
  logic [TIME_BITS-1:0] pulse_due;
  logic                 short_one;
  logic                 short_two;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign now        = in_data.now_time;
  assign med_one    = median3(in_data.sense_one_a, in_data.sense_one_b, in_data.sense_one_c);
  assign med_two    = median3(in_data.sense_two_a, in_data.sense_two_b, in_data.sense_two_c);
  assign settle_due = now + TIME_BITS'(settle_time_r);
  assign pulse_due  = pulse_start_r + TIME_BITS'(pulse_time_r);
  assign short_one  = ADC_BITS'(med_one) < path_threshold_r;
  assign short_two  = ADC_BITS'(med_two) < path_threshold_r;

  always_comb begin
    started_nxt     = started_r;
    phase_nxt       = phase_r;
    deadline_nxt    = deadline_r;
    active_nxt      = active_r;
    pulse_start_nxt = pulse_start_r;
    present_one_nxt = present_one_r;
    present_two_nxt = present_two_r;
    cycle_valid_nxt = cycle_valid_r;
    verdict_one_nxt = verdict_one_r;
    verdict_two_nxt = verdict_two_r;
    pins_nxt        = pins_r;

    if (in_data.func == FUNC_START) begin
      started_nxt     = 1'b1;
      pins_nxt        = 3'b100;
      active_nxt      = CH_NONE;
      cycle_valid_nxt = 1'b0;
      phase_nxt       = PH_LOW_ON;
      deadline_nxt    = settle_due;
    end else if (started_r && in_data.func == FUNC_FIRE) begin
      if (in_data.channel == CH_ONE || in_data.channel == CH_TWO) begin
        pins_nxt        = pins_r | {1'b1, in_data.channel == CH_TWO,
                                    in_data.channel == CH_ONE};
        active_nxt      = in_data.channel;
        pulse_start_nxt = now;
      end
    end else if (started_r && in_data.func == FUNC_TICK) begin
      if (active_r != CH_NONE) begin
        if (time_reached(now, pulse_due)) begin
          pins_nxt     = {1'b1,
                          pins_r[1] & (active_r != CH_TWO),
                          pins_r[0] & (active_r != CH_ONE)};
          active_nxt   = CH_NONE;
          phase_nxt    = PH_LOW_ON;
          deadline_nxt = settle_due;
        end
      end else if (time_reached(now, deadline_r)) begin
        case (phase_r)
          PH_LOW_ON: begin
            present_one_nxt = med_one;
            present_two_nxt = med_two;
            pins_nxt        = {1'b0, pins_r[1:0]};
            phase_nxt       = PH_LOW_OFF;
            deadline_nxt    = settle_due;
          end
          PH_LOW_OFF: begin
            verdict_one_nxt.count   = present_one_r;
            verdict_one_nxt.shorted = short_one;
            verdict_one_nxt.open    = present_one_r > open_threshold_r;
            verdict_one_nxt.good    = (present_one_r < path_threshold_r) & ~short_one;
            verdict_two_nxt.count   = present_two_r;
            verdict_two_nxt.shorted = short_two;
            verdict_two_nxt.open    = present_two_r > open_threshold_r;
            verdict_two_nxt.good    = (present_two_r < path_threshold_r) & ~short_two;
            cycle_valid_nxt = 1'b1;
            phase_nxt       = PH_IDLE;
            deadline_nxt    = now + TIME_BITS'(idle_time_r);
          end
          default: begin
            pins_nxt     = pins_r | 3'b100;
            phase_nxt    = PH_LOW_ON;
            deadline_nxt = settle_due;
          end
        endcase
      end
    end

    out_data_nxt.high_one_drive = pins_nxt[0];
    out_data_nxt.high_two_drive = pins_nxt[1];
    out_data_nxt.low_drive      = pins_nxt[2];
    out_data_nxt.firing         = active_nxt != CH_NONE;
    if (cycle_valid_nxt) begin
      out_data_nxt.one_count   = verdict_one_nxt.count;
      out_data_nxt.one_good    = verdict_one_nxt.good;
      out_data_nxt.one_open    = verdict_one_nxt.open;
      out_data_nxt.one_shorted = verdict_one_nxt.shorted;
      out_data_nxt.two_count   = verdict_two_nxt.count;
      out_data_nxt.two_good    = verdict_two_nxt.good;
      out_data_nxt.two_open    = verdict_two_nxt.open;
      out_data_nxt.two_shorted = verdict_two_nxt.shorted;
    end else begin
      out_data_nxt.one_count   = '0;
      out_data_nxt.one_good    = 1'b0;
      out_data_nxt.one_open    = 1'b1;
      out_data_nxt.one_shorted = 1'b0;
      out_data_nxt.two_count   = '0;
      out_data_nxt.two_good    = 1'b0;
      out_data_nxt.two_open    = 1'b1;
      out_data_nxt.two_shorted = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_threshold_r <= PATH_THRESHOLD_RST;
      open_threshold_r <= OPEN_THRESHOLD_RST;
      settle_time_r    <= SETTLE_TIME_RST;
      idle_time_r      <= IDLE_TIME_RST;
      pulse_time_r     <= PULSE_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATH_THRESHOLD: path_threshold_r <= cfg_data[TH_BITS-1:0];
        REG_OPEN_THRESHOLD: open_threshold_r <= cfg_data[TH_BITS-1:0];
        REG_SETTLE_TIME:    settle_time_r    <= cfg_data[DUR_BITS-1:0];
        REG_IDLE_TIME:      idle_time_r      <= cfg_data[DUR_BITS-1:0];
        REG_PULSE_TIME:     pulse_time_r     <= cfg_data[DUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r     <= 1'b0;
      phase_r       <= PH_LOW_ON;
      deadline_r    <= '0;
      active_r      <= CH_NONE;
      pulse_start_r <= '0;
      present_one_r <= '0;
      present_two_r <= '0;
      cycle_valid_r <= 1'b0;
      verdict_one_r <= '0;
      verdict_two_r <= '0;
      pins_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        started_r     <= started_nxt;
        phase_r       <= phase_nxt;
        deadline_r    <= deadline_nxt;
        active_r      <= active_nxt;
        pulse_start_r <= pulse_start_nxt;
        present_one_r <= present_one_nxt;
        present_two_r <= present_two_nxt;
        cycle_valid_r <= cycle_valid_nxt;
        verdict_one_r <= verdict_one_nxt;
        verdict_two_r <= verdict_two_nxt;
        pins_r        <= pins_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: hdl/igfcs_checker.sv
// Checker: port-level assertions for the igniter sequencer, bound to the top level.
module igfcs_checker
  import igfcs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input igfcs_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  a_firing_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.firing |-> out_data.low_drive)
    else $error("pulse without low-side drive");

  a_good_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.one_good && out_data.one_shorted) &&
                  !(out_data.two_good && out_data.two_shorted))
    else $error("channel reported good and shorted");

endmodule

bind igniter_fire_and_continuity_sequencer_unit igfcs_checker u_igfcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
